// ===== hdl/bhtm_pkg.sv =====
// shared constants, types and helpers for the binned histogram template matcher
package bhtm_pkg;

  localparam int GRID_ROWS      = 4;
  localparam int GRID_COLS      = 16;
  localparam int TEMPLATE_COUNT = 16;

  localparam int BIN_TOTAL   = GRID_ROWS * GRID_COLS;
  localparam int STORE_TOTAL = TEMPLATE_COUNT * BIN_TOTAL;
  localparam int BIN_W   = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;
  localparam int TPL_W   = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1;
  localparam int STORE_W = (STORE_TOTAL > 1) ? $clog2(STORE_TOTAL) : 1;

  // fixed field widths
  localparam int CH_W       = 8;
  localparam int CNT_W      = 16;
  localparam int ERR_W      = 24;
  localparam int POS_W      = 12;
  localparam int FW_W       = 13;
  localparam int BS_W       = 11;
  localparam int IDX_W      = 4;
  localparam int ROWF_W     = 2;
  localparam int COLF_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 24;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [FW_W-1:0]  FW_MAX  = FW_W'(1 << POS_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIDE         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT     = 2'd3;

  localparam logic [CH_W-1:0]  RST_BRIGHT_THRESHOLD = 8'd128;
  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH      = 13'd384;
  localparam logic [BS_W-1:0]  RST_BIN_SIDE         = 11'd16;
  localparam logic [ERR_W-1:0] RST_REJECT_LIMIT     = ERR_MAX;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SCAN,
    ST_WAIT,
    ST_POST
  } state_t;

  typedef struct packed {
    logic             in_grid;
    logic [BIN_W-1:0] bin;
  } bin_loc_t;

  typedef struct packed {
    logic             rd;
    logic [TPL_W-1:0] tpl;
    logic [BIN_W-1:0] bin;
  } scan_t;

  function automatic logic [STORE_W-1:0] store_addr(input int tpl, input int bin);
    return STORE_W'(tpl * BIN_TOTAL + bin);
  endfunction

endpackage

// ===== hdl/bhtm_position.sv =====
// raster position and bin tracking, with a serial re-divide after a bin size change
module bhtm_position import bhtm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            last,
  input  logic [FW_W-1:0] frame_width,
  input  logic [BS_W-1:0] bin_side,
  input  logic            redo,
  output bin_loc_t        loc,
  output logic            busy
);

  localparam int DV_W = $clog2(POS_W);

  logic [FW_W-1:0]  fw_eff;
  logic [BS_W-1:0]  bs_eff;
  logic [POS_W-1:0] col_pos, row_pos, col_q, row_q;
  logic [BS_W-1:0]  col_r, row_r;
  logic             col_wrap, col_r_end, row_r_end;

  logic [DV_W-1:0]  dv_cnt;
  logic [POS_W-1:0] dv_cn, dv_rn, dv_cq, dv_rq;
  logic [BS_W-1:0]  dv_cr, dv_rr;
  logic [BS_W:0]    col_step, row_step;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [BS_W:0] div_step(input logic [BS_W-1:0] rem, input logic nbit,
                                             input logic [BS_W-1:0] d);
    logic [BS_W:0] trial;
    trial = {rem, nbit};
    if (trial >= {1'b0, d}) begin
      return {1'b1, BS_W'(trial - {1'b0, d})};
    end
    return {1'b0, trial[BS_W-1:0]};
  endfunction

  always_comb begin
    if (frame_width == '0) begin
      fw_eff = FW_W'(1);
    end else if (frame_width > FW_MAX) begin
      fw_eff = FW_MAX;
    end else begin
      fw_eff = frame_width;
    end
    bs_eff    = (bin_side == '0) ? BS_W'(1) : bin_side;
    col_wrap  = (FW_W'(col_pos) + FW_W'(1)) >= fw_eff;
    col_r_end = ({1'b0, col_r} + 1'b1) == {1'b0, bs_eff};
    row_r_end = ({1'b0, row_r} + 1'b1) == {1'b0, bs_eff};
    col_step  = div_step(dv_cr, dv_cn[POS_W-1], bs_eff);
    row_step  = div_step(dv_rr, dv_rn[POS_W-1], bs_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      col_q   <= '0;
      row_q   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      busy    <= 1'b0;
      dv_cnt  <= '0;
      dv_cn   <= '0;
      dv_rn   <= '0;
      dv_cq   <= '0;
      dv_rq   <= '0;
      dv_cr   <= '0;
      dv_rr   <= '0;
    end else if (redo) begin
      busy   <= 1'b1;
      dv_cnt <= '0;
      dv_cn  <= col_pos;
      dv_rn  <= row_pos;
      dv_cq  <= '0;
      dv_rq  <= '0;
      dv_cr  <= '0;
      dv_rr  <= '0;
    end else if (busy) begin
      dv_cn <= {dv_cn[POS_W-2:0], 1'b0};
      dv_rn <= {dv_rn[POS_W-2:0], 1'b0};
      dv_cq <= {dv_cq[POS_W-2:0], col_step[BS_W]};
      dv_rq <= {dv_rq[POS_W-2:0], row_step[BS_W]};
      dv_cr <= col_step[BS_W-1:0];
      dv_rr <= row_step[BS_W-1:0];
      if (dv_cnt == DV_W'(POS_W - 1)) begin
        busy  <= 1'b0;
        col_q <= {dv_cq[POS_W-2:0], col_step[BS_W]};
        row_q <= {dv_rq[POS_W-2:0], row_step[BS_W]};
        col_r <= col_step[BS_W-1:0];
        row_r <= row_step[BS_W-1:0];
      end else begin
        dv_cnt <= dv_cnt + 1'b1;
      end
    end else if (adv) begin
      if (last) begin
        col_pos <= '0;
        row_pos <= '0;
        col_q   <= '0;
        row_q   <= '0;
        col_r   <= '0;
        row_r   <= '0;
      end else if (col_wrap) begin
        col_pos <= '0;
        col_q   <= '0;
        col_r   <= '0;
        // rows stick at the last position of a very tall frame
        if (row_pos < POS_MAX) begin
          row_pos <= row_pos + 1'b1;
          if (row_r_end) begin
            row_r <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
      end else begin
        col_pos <= col_pos + 1'b1;
        if (col_r_end) begin
          col_r <= '0;
          col_q <= col_q + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    loc.in_grid = (row_q < POS_W'(GRID_ROWS)) && (col_q < POS_W'(GRID_COLS));
    loc.bin     = BIN_W'(int'(row_q) * GRID_COLS + int'(col_q));
  end

endmodule

// ===== hdl/bhtm_hist.sv =====
// histogram memory with read-modify-write increment, sweep read and bulk clear
module bhtm_hist import bhtm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_inc,
  input  logic [BIN_W-1:0] pix_bin,
  input  scan_t            scan,
  input  logic             clear,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]     mem [BIN_TOTAL];
  logic [BIN_TOTAL-1:0] written;
  logic [CNT_W-1:0]     raw;
  logic                 raw_ok;
  logic                 s1_v, fw_v;
  logic [BIN_W-1:0]     s1_k, fw_k, rd_addr;
  logic [CNT_W-1:0]     fw_val, cur, upd;

  assign rd_addr = scan.rd ? scan.bin : pix_bin;

  always_comb begin
    // the write landing on the same edge as our read is not in raw
    if (fw_v && (fw_k == s1_k)) begin
      cur = fw_val;
    end else begin
      cur = raw_ok ? raw : '0;
    end
    upd     = (cur == CNT_MAX) ? cur : cur + 1'b1;
    rd_data = raw_ok ? raw : '0;
  end

  always_ff @(posedge clk) begin
    if (pix_inc || scan.rd) begin
      raw <= mem[rd_addr];
    end
    if (s1_v) begin
      mem[s1_k] <= upd;
    end
    s1_k   <= pix_bin;
    fw_k   <= s1_k;
    fw_val <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      s1_v    <= 1'b0;
      fw_v    <= 1'b0;
      raw_ok  <= 1'b0;
    end else begin
      s1_v <= pix_inc;
      fw_v <= s1_v;
      if (pix_inc || scan.rd) begin
        raw_ok <= written[rd_addr];
      end
      if (clear) begin
        written <= '0;
      end else if (s1_v) begin
        written[s1_k] <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/bhtm_score.sv =====
// template memory and the pipelined sum-of-absolute-differences scorer
module bhtm_score import bhtm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               ld_we,
  input  logic [STORE_W-1:0] ld_addr,
  input  logic [CNT_W-1:0]   ld_data,
  input  scan_t              scan,
  input  logic [CNT_W-1:0]   hist_data,
  output logic               done,
  output logic [ERR_W-1:0]   least_err,
  output logic [TPL_W-1:0]   best_index
);

  logic [CNT_W-1:0]   mem [STORE_TOTAL];
  logic [STORE_W-1:0] rd_addr;
  logic [CNT_W-1:0]   tw, d;
  logic               p1_v, p1_first, p1_lastb;
  logic               p2_v, p2_first, p2_lastb;
  logic               p3_done;
  logic [TPL_W-1:0]   p1_t, p2_t, p3_t;
  logic [ERR_W-1:0]   acc;
  logic [ERR_W:0]     sum;
  logic [ERR_W-1:0]   sum_sat;

  always_comb begin
    rd_addr = store_addr(int'(scan.tpl), int'(scan.bin));
    sum     = {1'b0, acc} + (ERR_W + 1)'(d);
    sum_sat = sum[ERR_W] ? ERR_MAX : sum[ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      mem[ld_addr] <= ld_data;
    end
    if (scan.rd) begin
      tw <= mem[rd_addr];
    end
    p1_first <= (scan.bin == '0);
    p1_lastb <= (scan.bin == BIN_W'(BIN_TOTAL - 1));
    p1_t     <= scan.tpl;
    p2_first <= p1_first;
    p2_lastb <= p1_lastb;
    p2_t     <= p1_t;
    d        <= (tw > hist_data) ? tw - hist_data : hist_data - tw;
    p3_t     <= p2_t;
    if (p2_v) begin
      acc <= p2_first ? ERR_W'(d) : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v       <= 1'b0;
      p2_v       <= 1'b0;
      p3_done    <= 1'b0;
      done       <= 1'b0;
      least_err  <= '0;
      best_index <= '0;
    end else begin
      p1_v    <= scan.rd;
      p2_v    <= p1_v;
      p3_done <= p2_v && p2_lastb;
      done    <= p3_done && (p3_t == TPL_W'(TEMPLATE_COUNT - 1));
      // strict compare keeps the first template on a tie
      if (p3_done && ((p3_t == '0) || (acc < least_err))) begin
        least_err  <= acc;
        best_index <= p3_t;
      end
    end
  end

endmodule

// ===== hdl/binned_histogram_template_match_top.sv =====
// top level: configuration, input decode, sweep control and result register
//
//  channel | signals                                           | accepted when
//  --------+---------------------------------------------------+-------------------------
//  config  | cfg_write cfg_index cfg_data                      | cfg_write high
//  input   | in_valid in_stall operation ... last_pixel        | in_valid & !in_stall
//  output  | out_valid out_stall match_found/index/error       | out_valid & !out_stall
//
//  loads and ordinary pixels are accepted back to back while in_stall is low.
//  a pixel with last_pixel set stalls the input for the matching pass: a drain state, a sweep
//  of 1024 template words (one per cycle), the scoring tail in the wait state and a post state.
//  a bin side write stalls the input while bin coordinates are re-divided.
//  reset empties the histogram at once through per-bin valid bits; no clearing pass.
//  a result held by out_stall only delays posting the next one, with the input stalled.
module binned_histogram_template_match_top import bhtm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [IDX_W-1:0]     template_index,
  input  logic [ROWF_W-1:0]    bin_row,
  input  logic [COLF_W-1:0]    bin_col,
  input  logic [CNT_W-1:0]     template_value,
  input  logic [CH_W-1:0]      blue,
  input  logic [CH_W-1:0]      green,
  input  logic [CH_W-1:0]      red,
  input  logic                 last_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 match_found,
  output logic [IDX_W-1:0]     match_index,
  output logic [ERR_W-1:0]     match_error
);

  logic [CH_W-1:0]    bright_threshold;
  logic [FW_W-1:0]    frame_width;
  logic [BS_W-1:0]    bin_side;
  logic [ERR_W-1:0]   reject_limit;

  state_t             state, state_next;
  logic               accept, pix_acc, ld_acc, bright, pix_inc, ld_we, ld_in_range;
  logic               bs_write, pos_busy, post_fire, score_done;
  bin_loc_t           loc;
  scan_t              scan;
  logic [TPL_W-1:0]   scan_tpl;
  logic [BIN_W-1:0]   scan_bin;
  logic               scan_end;
  logic [CNT_W-1:0]   hist_data;
  logic [ERR_W-1:0]   least_err;
  logic [TPL_W-1:0]   best_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_threshold <= RST_BRIGHT_THRESHOLD;
      frame_width      <= RST_FRAME_WIDTH;
      bin_side         <= RST_BIN_SIDE;
      reject_limit     <= RST_REJECT_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BRIGHT_THRESHOLD: bright_threshold <= cfg_data[CH_W-1:0];
        REG_FRAME_WIDTH:      frame_width      <= cfg_data[FW_W-1:0];
        REG_BIN_SIDE:         bin_side         <= cfg_data[BS_W-1:0];
        REG_REJECT_LIMIT:     reject_limit     <= cfg_data[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bs_write    = cfg_write && (cfg_index == REG_BIN_SIDE);
    accept      = in_valid && !in_stall;
    pix_acc     = accept && (operation == OP_PIXEL);
    ld_acc      = accept && (operation == OP_LOAD);
    bright      = (blue > bright_threshold) && (green > bright_threshold) &&
                  (red > bright_threshold);
    pix_inc     = pix_acc && bright && loc.in_grid;
    ld_in_range = (int'(template_index) < TEMPLATE_COUNT) && (int'(bin_row) < GRID_ROWS) &&
                  (int'(bin_col) < GRID_COLS);
    ld_we       = ld_acc && ld_in_range;
    scan_end    = (scan_tpl == TPL_W'(TEMPLATE_COUNT - 1)) &&
                  (scan_bin == BIN_W'(BIN_TOTAL - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    scan.rd    = 1'b0;
    scan.tpl   = scan_tpl;
    scan.bin   = scan_bin;
    post_fire  = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_stall = pos_busy || bs_write;
        if (pix_acc && last_pixel) begin
          state_next = ST_DRAIN;
        end
      end
      // let the last increment land before the sweep reads the histogram
      ST_DRAIN: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        scan.rd = 1'b1;
        if (scan_end) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (score_done) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        if (!out_valid || !out_stall) begin
          post_fire  = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_tpl <= '0;
      scan_bin <= '0;
    end else if (scan.rd) begin
      if (scan_bin == BIN_W'(BIN_TOTAL - 1)) begin
        scan_bin <= '0;
        scan_tpl <= (scan_tpl == TPL_W'(TEMPLATE_COUNT - 1)) ? '0 : scan_tpl + 1'b1;
      end else begin
        scan_bin <= scan_bin + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_fire) begin
      match_found <= (least_err <= reject_limit);
      match_index <= IDX_W'(best_index);
      match_error <= least_err;
    end
  end

  bhtm_position u_position (
    .clk         (clk),
    .rst         (rst),
    .adv         (pix_acc),
    .last        (last_pixel),
    .frame_width (frame_width),
    .bin_side    (bin_side),
    .redo        (bs_write),
    .loc         (loc),
    .busy        (pos_busy)
  );

  bhtm_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .pix_inc (pix_inc),
    .pix_bin (loc.bin),
    .scan    (scan),
    .clear   (post_fire),
    .rd_data (hist_data)
  );

  bhtm_score u_score (
    .clk        (clk),
    .rst        (rst),
    .ld_we      (ld_we),
    .ld_addr    (store_addr(int'(template_index), int'(bin_row) * GRID_COLS + int'(bin_col))),
    .ld_data    (template_value),
    .scan       (scan),
    .hist_data  (hist_data),
    .done       (score_done),
    .least_err  (least_err),
    .best_index (best_index)
  );

  a_post_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_POST))
    else $error("result posted outside the post state");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && last_pixel) |=> (state == ST_DRAIN))
    else $error("last pixel did not start the matching pass");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pix_inc && scan.rd))
    else $error("pixel increment during histogram sweep");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    score_done |-> (state == ST_WAIT))
    else $error("scoring finished outside the wait state");

endmodule

// ===== verif/bhtm_match_checker.sv =====
// checker for the template matcher: mirrors histogram and templates, scores each frame
`timescale 1ns / 1ps
module bhtm_match_checker import bhtm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 operation,
  input  logic [IDX_W-1:0]     template_index,
  input  logic [ROWF_W-1:0]    bin_row,
  input  logic [COLF_W-1:0]    bin_col,
  input  logic [CNT_W-1:0]     template_value,
  input  logic [CH_W-1:0]      blue,
  input  logic [CH_W-1:0]      green,
  input  logic [CH_W-1:0]      red,
  input  logic                 last_pixel,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 match_found,
  input  logic [IDX_W-1:0]     match_index,
  input  logic [ERR_W-1:0]     match_error,
  output int                   failures,
  output int                   pending
);

  localparam int unsigned ROW_TOP    = POS_MAX;
  localparam int unsigned WIDTH_CAP  = ROW_TOP + 1;
  localparam int unsigned SCORE_TOP  = ERR_MAX;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [ERR_W-1:0] err;
  } match_t;

  match_t           expected_matches[$];
  match_t           want;
  logic [CNT_W-1:0] template_words [STORE_TOTAL];
  logic [CNT_W-1:0] bin_hist [BIN_TOTAL];
  logic [CH_W-1:0]  thr_reg;
  logic [FW_W-1:0]  width_reg;
  logic [BS_W-1:0]  bin_reg;
  logic [ERR_W-1:0] limit_reg;
  int unsigned      col_pos, row_pos, eff_width, eff_bin, hit_row, hit_col, slot;
  int unsigned      err_sum, best_err, best_idx, diff, word;

  always @(posedge clk) begin
    if (rst) begin
      failures  = 0;
      thr_reg   = RST_BRIGHT_THRESHOLD;
      width_reg = RST_FRAME_WIDTH;
      bin_reg   = RST_BIN_SIDE;
      limit_reg = RST_REJECT_LIMIT;
      foreach (bin_hist[k]) bin_hist[k] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_matches.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          $error("result with no frame pending: found %0d index %0d error %0d",
                 match_found, match_index, match_error);
          failures++;
        end else begin
          want = expected_matches.pop_front();
          if (match_found !== want.found) begin
            $error("match_found: expected %0d, got %0d", want.found, match_found);
            failures++;
          end
          if (match_index !== want.idx) begin
            $error("match_index: expected %0d, got %0d", want.idx, match_index);
            failures++;
          end
          if (match_error !== want.err) begin
            $error("match_error: expected %0d, got %0d", want.err, match_error);
            failures++;
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_BRIGHT_THRESHOLD: thr_reg   = cfg_data[CH_W-1:0];
          REG_FRAME_WIDTH:      width_reg = cfg_data[FW_W-1:0];
          REG_BIN_SIDE:         bin_reg   = cfg_data[BS_W-1:0];
          REG_REJECT_LIMIT:     limit_reg = cfg_data[ERR_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (operation == OP_LOAD) begin
          template_words[int'(template_index) * BIN_TOTAL + int'(bin_row) * GRID_COLS
                         + int'(bin_col)] = template_value;
        end else begin
          eff_width = (width_reg == 0) ? 1 : width_reg;
          if (eff_width > WIDTH_CAP) eff_width = WIDTH_CAP;
          eff_bin = (bin_reg == 0) ? 1 : bin_reg;

          if (blue > thr_reg && green > thr_reg && red > thr_reg) begin
            hit_row = row_pos / eff_bin;
            hit_col = col_pos / eff_bin;
            // pixels beyond the grid are dropped
            if (hit_row < GRID_ROWS && hit_col < GRID_COLS) begin
              slot = hit_row * GRID_COLS + hit_col;
              if (bin_hist[slot] != CNT_MAX) bin_hist[slot] = bin_hist[slot] + 1'b1;
            end
          end

          if (col_pos + 1 >= eff_width) begin
            col_pos = 0;
            if (row_pos < ROW_TOP) row_pos++;
          end else begin
            col_pos++;
          end

          if (last_pixel) begin
            best_err = 0;
            best_idx = 0;
            for (int t = 0; t < TEMPLATE_COUNT; t++) begin
              err_sum = 0;
              for (int b = 0; b < BIN_TOTAL; b++) begin
                word = template_words[t * BIN_TOTAL + b];
                diff = (word > bin_hist[b]) ? word - bin_hist[b] : bin_hist[b] - word;
                err_sum += diff;
                if (err_sum > SCORE_TOP) err_sum = SCORE_TOP;
              end
              // strict compare keeps the first template on a tie
              if (t == 0 || err_sum < best_err) begin
                best_err = err_sum;
                best_idx = t;
              end
            end
            want.found = (best_err <= limit_reg);
            want.idx   = IDX_W'(best_idx);
            want.err   = ERR_W'(best_err);
            expected_matches.push_back(want);
            foreach (bin_hist[k]) bin_hist[k] = '0;
            col_pos = 0;
            row_pos = 0;
          end
        end
      end
    end
    pending <= expected_matches.size();
  end

endmodule

// ===== verif/binned_histogram_template_match_top_tb.sv =====
// testbench top for the template matcher: clock, reset, stimulus phases and verdict
`timescale 1ns / 1ps
module binned_histogram_template_match_top_tb;
  import bhtm_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 operation;
  logic [IDX_W-1:0]     template_index;
  logic [ROWF_W-1:0]    bin_row;
  logic [COLF_W-1:0]    bin_col;
  logic [CNT_W-1:0]     template_value;
  logic [CH_W-1:0]      blue;
  logic [CH_W-1:0]      green;
  logic [CH_W-1:0]      red;
  logic                 last_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic                 match_found;
  logic [IDX_W-1:0]     match_index;
  logic [ERR_W-1:0]     match_error;

  int                   failures;
  int                   pending;
  int                   idle_pct;
  int                   stall_pct;
  int                   items_sent;
  logic [CH_W-1:0]      cur_thr;
  logic [CNT_W-1:0]     twin_words [BIN_TOTAL];

  binned_histogram_template_match_top DUT (.*);

  bhtm_match_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic push_item(input logic op, input logic [IDX_W-1:0] t,
                           input logic [ROWF_W-1:0] r, input logic [COLF_W-1:0] c,
                           input logic [CNT_W-1:0] v, input logic [CH_W-1:0] b,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] rd,
                           input logic lst);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    template_index <= t;
    bin_row        <= r;
    bin_col        <= c;
    template_value <= v;
    blue           <= b;
    green          <= g;
    red            <= rd;
    last_pixel     <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // pixel fields carry noise on a load, as the block ignores them
  task automatic load_word(input logic [IDX_W-1:0] t, input logic [ROWF_W-1:0] r,
                           input logic [COLF_W-1:0] c, input logic [CNT_W-1:0] v,
                           input logic lst);
    push_item(OP_LOAD, t, r, c, v, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
              CH_W'($urandom_range(255)), lst);
  endtask

  task automatic pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                       input logic [CH_W-1:0] rd, input logic lst);
    push_item(OP_PIXEL, IDX_W'($urandom_range(15)), ROWF_W'($urandom_range(3)),
              COLF_W'($urandom_range(15)), CNT_W'($urandom_range(65535)), b, g, rd, lst);
  endtask

  // mostly sparse small counts, the odd extreme word
  function automatic logic [CNT_W-1:0] sparse_word();
    case ($urandom_range(19))
      0:       return CNT_MAX;
      1:       return CNT_W'($urandom_range(65535));
      2, 3, 4: return CNT_W'($urandom_range(1, 3));
      default: return '0;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] lit_channel();
    if (cur_thr == 8'hFF) return 8'hFF;
    return CH_W'($urandom_range(255, cur_thr + 1));
  endfunction

  task automatic send_frame(input int n, input int bright_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4)
        load_word(IDX_W'($urandom_range(15)), ROWF_W'($urandom_range(3)),
                  COLF_W'($urandom_range(15)), sparse_word(), 1'($urandom_range(1)));
      if ($urandom_range(99) < bright_pct)
        pixel(lit_channel(), lit_channel(), lit_channel(), i == n - 1);
      else
        pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
              CH_W'($urandom_range(255)), i == n - 1);
    end
  endtask

  // wait until every frame score is back and the block has gone quiet
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CH_W-1:0] thr, input logic [FW_W-1:0] fw,
                          input logic [BS_W-1:0] bs, input logic [ERR_W-1:0] lim);
    logic [CFG_W-1:0] junk;
    settle(20);
    junk    = CFG_W'($urandom);
    cur_thr = thr;
    cfg_write <= 1'b1;
    cfg_index <= REG_BRIGHT_THRESHOLD;
    cfg_data  <= {junk[CFG_W-1:CH_W], thr};
    @(posedge clk);
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= {junk[CFG_W-1:FW_W], fw};
    @(posedge clk);
    cfg_index <= REG_BIN_SIDE;
    cfg_data  <= {junk[CFG_W-1:BS_W], bs};
    @(posedge clk);
    cfg_index <= REG_REJECT_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [CH_W-1:0]  thr_v;
    logic [FW_W-1:0]  fw_v;
    logic [BS_W-1:0]  bs_v;
    logic [ERR_W-1:0] lim_v;
    logic [CNT_W-1:0] w;
    int               target;

    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_BRIGHT_THRESHOLD;
    cfg_data       = '0;
    in_valid       = 1'b0;
    operation      = OP_LOAD;
    template_index = '0;
    bin_row        = '0;
    bin_col        = '0;
    template_value = '0;
    blue           = '0;
    green          = '0;
    red            = '0;
    last_pixel     = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    items_sent     = 0;
    cur_thr        = RST_BRIGHT_THRESHOLD;
    foreach (twin_words[k]) twin_words[k] = sparse_word();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every template word is written before any frame ends
    for (int t = 0; t < TEMPLATE_COUNT; t++) begin
      for (int b = 0; b < BIN_TOTAL; b++) begin
        if (t == 13)      w = CNT_MAX;
        else if (t >= 14) w = twin_words[b];  // identical pair, tie goes to the lower index
        else              w = sparse_word();
        load_word(IDX_W'(t), ROWF_W'(b / GRID_COLS), COLF_W'(b % GRID_COLS), w,
                  1'($urandom_range(1)));
      end
    end

    // zero width and zero bin size act as one: a single column, row four off the grid
    set_regs(8'd0, 13'd0, 11'd0, 24'd0);
    pixel(8'd0, 8'd0, 8'd0, 1'b0);
    pixel(8'd1, 8'd1, 8'd1, 1'b0);
    pixel(8'd1, 8'd0, 8'd255, 1'b0);
    pixel(8'd255, 8'd255, 8'd255, 1'b0);
    pixel(8'd255, 8'd255, 8'd255, 1'b1);
    // last flag on a load must not end the frame
    load_word(4'd2, 2'd3, 4'd15, CNT_MAX, 1'b1);
    // top threshold lights nothing, width above the cap
    set_regs(8'd255, 13'd8191, 11'd2047, ERR_MAX);
    pixel(8'd255, 8'd255, 8'd255, 1'b0);
    pixel(8'd0, 8'd0, 8'd0, 1'b1);
    // a channel equal to the threshold is not bright
    set_regs(8'd128, 13'd4, 11'd1, ERR_MAX);
    pixel(8'd129, 8'd129, 8'd129, 1'b0);
    pixel(8'd128, 8'd255, 8'd255, 1'b0);
    pixel(8'd255, 8'd128, 8'd255, 1'b0);
    pixel(8'd255, 8'd255, 8'd128, 1'b0);
    pixel(8'd129, 8'd129, 8'd129, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 58; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        case ($urandom_range(5))
          0:       thr_v = 8'd0;
          1:       thr_v = 8'd255;
          2:       thr_v = CH_W'($urandom_range(255));
          default: thr_v = CH_W'($urandom_range(90, 170));
        endcase
        case ($urandom_range(9))
          0:       fw_v = 13'd0;
          1:       fw_v = 13'd1;
          2:       fw_v = 13'd8191;
          3:       fw_v = 13'd4096;
          4:       fw_v = FW_W'($urandom_range(8191));
          default: fw_v = FW_W'($urandom_range(2, 24));
        endcase
        case ($urandom_range(9))
          0:       bs_v = 11'd0;
          1:       bs_v = 11'd2047;
          2:       bs_v = 11'd1024;
          3:       bs_v = BS_W'($urandom_range(2047));
          default: bs_v = BS_W'($urandom_range(1, 3));
        endcase
        case ($urandom_range(5))
          0:       lim_v = 24'd0;
          1:       lim_v = ERR_MAX;
          2:       lim_v = ERR_W'($urandom_range(16777215));
          default: lim_v = ERR_W'($urandom_range(300));
        endcase
        set_regs(thr_v, fw_v, bs_v, lim_v);
        target = items_sent + 45;
        while (items_sent < target) send_frame($urandom_range(1, 48), $urandom_range(100));
      end
    end

    settle(1100);
    if (failures == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
